### hdl/ate_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ate_pkg;

  localparam int unsigned ColW    = 6;
  localparam int unsigned RowW    = 5;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegColumns  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRows     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxPrint = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDefFg    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDefBg    = 3'd4;

  localparam logic [7:0] ChEsc = 8'h1B;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChBel = 8'h07;
  localparam logic [7:0] ChTab = 8'h09;

  typedef enum logic [1:0] {
    PsReady = 2'd0,
    PsEsc   = 2'd1,
    PsCsi   = 2'd2
  } parse_state_e;

  typedef enum logic [3:0] {
    OpNone, OpPrint, OpBs, OpLf, OpCr, OpClear, OpBell, OpTab, OpFinal
  } op_e;

  // classified byte handed from the front to the back
  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
  } cmd_t;

  typedef struct packed {
    logic        write_cell;
    logic [5:0]  cell_col;
    logic [4:0]  cell_row;
    logic [7:0]  cell_char;
    logic [15:0] cell_fg;
    logic [15:0] cell_bg;
    logic [4:0]  scroll_lines;
    logic        clear_screen;
    logic        beep;
    logic [5:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        cursor_shown;
  } res_t;

  function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [7:0] sat8(input logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [15:0] palette(input logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0:  v = rgb565(8'h00, 8'h00, 8'h00);
      4'd1:  v = rgb565(8'hAA, 8'h00, 8'h00);
      4'd2:  v = rgb565(8'h00, 8'hAA, 8'h00);
      4'd3:  v = rgb565(8'hAA, 8'h55, 8'h00);
      4'd4:  v = rgb565(8'h00, 8'h00, 8'hAA);
      4'd5:  v = rgb565(8'hAA, 8'h00, 8'hAA);
      4'd6:  v = rgb565(8'h00, 8'hAA, 8'hAA);
      4'd7:  v = rgb565(8'hAA, 8'hAA, 8'hAA);
      4'd8:  v = rgb565(8'h55, 8'h55, 8'h55);
      4'd9:  v = rgb565(8'hFF, 8'h55, 8'h55);
      4'd10: v = rgb565(8'h55, 8'hFF, 8'h55);
      4'd11: v = rgb565(8'hFF, 8'hFF, 8'h55);
      4'd12: v = rgb565(8'h00, 8'h00, 8'hFF);
      4'd13: v = rgb565(8'hFF, 8'h55, 8'hFF);
      4'd14: v = rgb565(8'h55, 8'hFF, 8'hFF);
      default: v = rgb565(8'hFF, 8'hFF, 8'hFF);
    endcase
    return v;
  endfunction

  // 256-colour index to rgb565, cube digits by reciprocal multiply (36 and 6)
  function automatic logic [15:0] indexed(input logic [7:0] n);
    logic [7:0]  c;
    logic [15:0] rq;
    logic [7:0]  r;
    logic [7:0]  rem;
    logic [15:0] gq;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  gr;
    logic [15:0] v;
    c   = n - 8'd16;
    rq  = {8'd0, c} * 16'd57;
    r   = {5'd0, rq[13:11]};
    rem = c - r * 8'd36;
    gq  = {8'd0, rem} * 16'd43;
    g   = {5'd0, gq[10:8]};
    b   = rem - g * 8'd6;
    gr  = (n - 8'd232) * 8'd10;
    if (n <= 8'd15) begin
      v = palette(n[3:0]);
    end else if (n <= 8'd231) begin
      v = rgb565(r * 8'd42, g * 8'd42, b * 8'd42);
    end else begin
      v = rgb565(gr, gr, gr);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/ate_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ate_front import ate_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] max_printable_i,
  output logic            full_o,
  output logic            valid_o,
  output cmd_t            cmd_o,
  input  wire logic       ready_i
);

  logic  valid_q, valid_d;
  cmd_t  cmd_q, cmd_d;
  parse_state_e state_q, state_d;
  logic  take;

  assign full_o  = valid_q && !ready_i;
  assign take    = push_i && !full_o;
  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

  always_comb begin
    state_d  = state_q;
    cmd_d.op = OpNone;
    cmd_d.ch = rx_byte_i;
    unique case (state_q)
      PsEsc: begin
        state_d = PsReady;
        if (rx_byte_i == "[") begin
          state_d  = PsCsi;
          cmd_d.op = OpNone;
        end
      end
      PsCsi: begin
        if (rx_byte_i >= 8'h40 && rx_byte_i < 8'h7E) begin
          state_d  = PsReady;
          cmd_d.op = OpFinal;
        end
      end
      default: begin
        state_d = PsReady;
        if (state_q == PsReady) begin
          if (rx_byte_i >= 8'h20 && rx_byte_i <= max_printable_i) cmd_d.op = OpPrint;
          else if (rx_byte_i == ChEsc) state_d = PsEsc;
          else if (rx_byte_i == ChBs)  cmd_d.op = OpBs;
          else if (rx_byte_i == ChLf)  cmd_d.op = OpLf;
          else if (rx_byte_i == ChCr)  cmd_d.op = OpCr;
          else if (rx_byte_i == ChFf)  cmd_d.op = OpClear;
          else if (rx_byte_i == ChBel) cmd_d.op = OpBell;
          else if (rx_byte_i == ChTab) cmd_d.op = OpTab;
        end
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (ready_i) valid_d = 1'b0;
    if (take) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      state_q <= PsReady;
    end else begin
      valid_q <= valid_d;
      if (take) state_q <= state_d;
    end
  end

  // params digits are passed as OpNone with the byte, back decodes in csi state
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule
`default_nettype wire

### hdl/ate_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ate_back import ate_pkg::*; #(
  parameter int unsigned MaxCols   = 52,
  parameter int unsigned MaxRows   = 30,
  parameter int unsigned NumParams = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  cmd_t             cmd_i,
  input  wire logic        csi_open_i,
  input  wire logic        csi_body_i,
  input  wire logic [5:0]  columns_i,
  input  wire logic [4:0]  rows_i,
  input  wire logic        clamp_i,
  input  wire logic [15:0] def_fg_i,
  input  wire logic [15:0] def_bg_i,
  input  wire logic        def_fg_we_i,
  output logic             ready_o,
  output logic             res_valid_o,
  output res_t             res_o,
  input  wire logic        res_ready_i
);

  localparam int unsigned PiW  = $clog2(NumParams + 1);
  localparam int unsigned IdxW = (NumParams > 1) ? $clog2(NumParams) : 1;

  logic [15:0] par_q [NumParams];
  logic [PiW-1:0] pi_q;
  logic [IdxW-1:0] pix;
  logic priv_q, vis_q;
  logic [5:0] col_q, scol_q;
  logic [4:0] row_q, srow_q;
  logic [15:0] fg_q, bg_q;
  logic rv_q;
  res_t res_q;
  logic go;

  logic [5:0] ec;
  logic [4:0] er;
  always_comb begin
    ec = (columns_i == 6'd0) ? 6'd1 : columns_i;
    if (32'(ec) > MaxCols) ec = 6'(MaxCols);
    er = (rows_i == 5'd0) ? 5'd1 : rows_i;
    if (32'(er) > MaxRows) er = 5'(MaxRows);
  end

  assign ready_o = !rv_q || res_ready_i;
  assign go      = valid_i && ready_o;
  assign res_valid_o = rv_q;
  assign res_o   = res_q;

  logic [15:0] p0, p1, p2, n;
  logic [15:0] dig;
  logic [19:0] acc;
  logic [5:0]  col_d;
  logic [4:0]  row_d;
  logic [15:0] fg_d, bg_d;
  logic        vis_d, do_clr;
  logic [5:0]  scol_d;
  logic [4:0]  srow_d;
  logic [4:0]  scr;
  logic [16:0] sum;
  logic [15:0] rowm, colm, tmp;
  logic [15:0] idxc, tc;
  res_t        r;

  assign pix = pi_q[IdxW-1:0];
  assign p0 = par_q[0];
  assign p1 = par_q[1];
  assign p2 = par_q[2];
  assign n  = (p0 == 16'd0) ? 16'd1 : p0;
  assign dig = {12'd0, cmd_i.ch[3:0]};
  assign acc = {4'd0, par_q[pix]} * 20'd10 + {4'd0, dig};

  always_comb begin
    col_d = col_q; row_d = row_q; fg_d = fg_q; bg_d = bg_q; vis_d = vis_q;
    scol_d = scol_q; srow_d = srow_q; scr = '0; do_clr = 1'b0;
    r = '0; sum = '0; rowm = '0; colm = '0; tmp = '0;
    idxc = indexed(p2[7:0]);
    tc = rgb565(sat8(p2), sat8(par_q[3]), sat8(par_q[4]));
    unique case (cmd_i.op)
      OpPrint: begin
        r.write_cell = 1'b1; r.cell_col = col_q; r.cell_row = row_q;
        r.cell_char = cmd_i.ch; r.cell_fg = fg_q; r.cell_bg = bg_q;
        if (col_q + 6'd1 >= ec) begin
          col_d = '0;
          if (row_q + 5'd1 >= er) begin row_d = er - 5'd1; scr = 5'd1; end
          else row_d = row_q + 5'd1;
        end else col_d = col_q + 6'd1;
      end
      OpBs: if (col_q != 6'd0) col_d = col_q - 6'd1;
      OpLf: begin
        col_d = '0;
        if (row_q + 5'd1 >= er) begin row_d = er - 5'd1; scr = 5'd1; end
        else row_d = row_q + 5'd1;
      end
      OpCr: col_d = '0;
      OpClear: do_clr = 1'b1;
      OpBell: r.beep = 1'b1;
      OpTab: begin
        tmp = {10'd0, col_q + 6'd8} & 16'hFFF8;
        if (col_q >= 6'd56) tmp = 16'd64;
        col_d = (tmp >= {10'd0, ec}) ? ec - 6'd1 : tmp[5:0];
      end
      OpFinal: begin
        unique case (cmd_i.ch)
          "H": begin
            rowm = (p0 == 0) ? 16'd0 : p0 - 16'd1;
            colm = (p1 == 0) ? 16'd0 : p1 - 16'd1;
            row_d = (rowm >= {11'd0, er}) ? er - 5'd1 : rowm[4:0];
            col_d = (colm >= {10'd0, ec}) ? ec - 6'd1 : colm[5:0];
          end
          "h": if (priv_q && p0 == 16'd25) vis_d = 1'b1;
          "l": if (priv_q && p0 == 16'd25) vis_d = 1'b0;
          "s": begin scol_d = col_q; srow_d = row_q; end
          "u": begin col_d = scol_q; row_d = srow_q; end
          "J": if (p0 == 16'd2 || p0 == 16'd3) do_clr = 1'b1;
          "A": row_d = ({11'd0, row_q} >= n) ? row_q - n[4:0] : 5'd0;
          "B": begin
            sum = {12'd0, row_q} + {1'b0, n};
            row_d = (sum >= {12'd0, er}) ? er - 5'd1 : sum[4:0];
          end
          "C": begin
            sum = {11'd0, col_q} + {1'b0, n};
            col_d = (sum >= {11'd0, ec}) ? ec - 6'd1 : sum[5:0];
          end
          "D": col_d = ({10'd0, col_q} >= n) ? col_q - n[5:0] : 6'd0;
          "S": scr = (n > {11'd0, er}) ? er : n[4:0];
          "m": begin
            if (p0 >= 30 && p0 <= 37)   fg_d = palette(4'(p0 - 16'd30));
            if (p0 >= 40 && p0 <= 47)   bg_d = palette(4'(p0 - 16'd40));
            if (p0 >= 90 && p0 <= 97)   fg_d = palette(4'(p0 - 16'd82));
            if (p0 >= 100 && p0 <= 107) bg_d = palette(4'(p0 - 16'd92));
            if (p1 == 16'd5 && p2 <= 16'd255) begin
              if (p0 == 16'd38) fg_d = idxc;
              if (p0 == 16'd48) bg_d = idxc;
            end
            if (p1 == 16'd2) begin
              if (p0 == 16'd38) fg_d = tc;
              if (p0 == 16'd48) bg_d = tc;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (do_clr) begin
      col_d = '0; row_d = '0; fg_d = def_fg_i; bg_d = def_bg_i;
    end
    r.scroll_lines = scr;
    r.clear_screen = do_clr;
    r.cursor_col = col_d;
    r.cursor_row = row_d;
    r.cursor_shown = vis_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0; pi_q <= '0; priv_q <= 1'b0; vis_q <= 1'b1;
      col_q <= '0; row_q <= '0; scol_q <= '0; srow_q <= '0;
      fg_q <= 16'd2016; bg_q <= '0; res_q <= '0;
      for (int i = 0; i < NumParams; i++) par_q[i] <= '0;
    end else begin
      if (def_fg_we_i) begin
        // nothing: colours follow defaults only on clear
      end
      if (go) begin
        rv_q <= 1'b1;
        res_q <= r;
        col_q <= col_d; row_q <= row_d; fg_q <= fg_d; bg_q <= bg_d;
        vis_q <= vis_d; scol_q <= scol_d; srow_q <= srow_d;
        if (csi_open_i || cmd_i.op == OpFinal) begin
          pi_q <= '0; priv_q <= 1'b0;
          for (int i = 0; i < NumParams; i++) par_q[i] <= '0;
        end else if (csi_body_i) begin
          if (cmd_i.ch >= "0" && cmd_i.ch <= "9") begin
            if (32'(pi_q) < NumParams)
              par_q[pix] <= (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
          end else if (cmd_i.ch == ";") begin
            if (32'(pi_q) < NumParams) pi_q <= pi_q + 1'b1;
          end else if (cmd_i.ch == "?") begin
            priv_q <= 1'b1;
          end
        end
      end else begin
        if (res_ready_i) rv_q <= 1'b0;
        if (clamp_i) begin
          if (col_q >= ec) col_q <= ec - 6'd1;
          if (row_q >= er) row_q <= er - 5'd1;
          if (scol_q >= ec) scol_q <= ec - 6'd1;
          if (srow_q >= er) srow_q <= er - 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hdl/ansi_terminal_escape_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ANSI terminal parser: one byte in, one result word out per byte. A byte is
// classified and registered in the front stage, then carried out in the back
// stage; one byte per cycle is sustained while results are popped, and each stage
// holds one word, so a byte still goes in while a finished result waits to be popped.
module ansi_terminal_escape_parser import ate_pkg::*; #(
  parameter int unsigned MAX_COLS   = 52,
  parameter int unsigned MAX_ROWS   = 30,
  parameter int unsigned NUM_PARAMS = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     write_cell_o,
  output logic [5:0]               cell_col_o,
  output logic [4:0]               cell_row_o,
  output logic [7:0]               cell_char_o,
  output logic [15:0]              cell_fg_o,
  output logic [15:0]              cell_bg_o,
  output logic [4:0]               scroll_lines_o,
  output logic                     clear_screen_o,
  output logic                     beep_o,
  output logic [5:0]               cursor_col_o,
  output logic [4:0]               cursor_row_o,
  output logic                     cursor_shown_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  logic [5:0]  columns_q;
  logic [4:0]  rows_q;
  logic [7:0]  maxp_q;
  logic [15:0] dfg_q, dbg_q;
  logic        clamp_q;
  logic        fvalid, bready, rvalid;
  cmd_t        cmd;
  res_t        res;
  parse_state_e st_q;
  logic        open_q, body_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 6'd40; rows_q <= 5'd30; maxp_q <= 8'd255;
      dfg_q <= 16'd2016; dbg_q <= '0; clamp_q <= 1'b0;
    end else begin
      clamp_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegColumns:  begin columns_q <= cfg_data_i[5:0]; clamp_q <= 1'b1; end
          RegRows:     begin rows_q <= cfg_data_i[4:0]; clamp_q <= 1'b1; end
          RegMaxPrint: maxp_q <= cfg_data_i[7:0];
          RegDefFg:    dfg_q <= cfg_data_i;
          RegDefBg:    dbg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // track csi context alongside the front so the back knows parameter bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PsReady; open_q <= 1'b0; body_q <= 1'b0;
    end else if (push && !full) begin
      open_q <= (st_q == PsEsc) && (rx_byte_i == "[");
      body_q <= (st_q == PsCsi);
      unique case (st_q)
        PsEsc:   st_q <= (rx_byte_i == "[") ? PsCsi : PsReady;
        PsCsi:   if (rx_byte_i >= 8'h40 && rx_byte_i < 8'h7E) st_q <= PsReady;
        default: if (!(rx_byte_i >= 8'h20 && rx_byte_i <= maxp_q) && rx_byte_i == ChEsc)
                   st_q <= PsEsc;
                 else st_q <= PsReady;
      endcase
    end
  end

  ate_front u_front (
    .clk_i, .rst_ni, .push_i(push), .rx_byte_i, .max_printable_i(maxp_q),
    .full_o(full), .valid_o(fvalid), .cmd_o(cmd), .ready_i(bready)
  );

  ate_back #(.MaxCols(MAX_COLS), .MaxRows(MAX_ROWS), .NumParams(NUM_PARAMS)) u_back (
    .clk_i, .rst_ni, .valid_i(fvalid), .cmd_i(cmd),
    .csi_open_i(open_q), .csi_body_i(body_q && cmd.op != OpFinal),
    .columns_i(columns_q), .rows_i(rows_q), .clamp_i(clamp_q),
    .def_fg_i(dfg_q), .def_bg_i(dbg_q), .def_fg_we_i(1'b0),
    .ready_o(bready), .res_valid_o(rvalid), .res_o(res), .res_ready_i(pop)
  );

  assign empty          = !rvalid;
  assign write_cell_o   = res.write_cell;
  assign cell_col_o     = res.cell_col;
  assign cell_row_o     = res.cell_row;
  assign cell_char_o    = res.cell_char;
  assign cell_fg_o      = res.cell_fg;
  assign cell_bg_o      = res.cell_bg;
  assign scroll_lines_o = res.scroll_lines;
  assign clear_screen_o = res.clear_screen;
  assign beep_o         = res.beep;
  assign cursor_col_o   = res.cursor_col;
  assign cursor_row_o   = res.cursor_row;
  assign cursor_shown_o = res.cursor_shown;

endmodule
`default_nettype wire

### hdl/ate_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ate_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       write_cell_o,
  input wire logic [5:0] cell_col_o,
  input wire logic [5:0] cursor_col_o,
  input wire logic       beep_o,
  input wire logic       clear_screen_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("word lost while stalled");

  a_nocell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !write_cell_o) |-> (cell_col_o == 6'd0)) else $error("stray cell column");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(write_cell_o && (beep_o || clear_screen_o))) else $error("mixed word");

  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && clear_screen_o) |-> (cursor_col_o == 6'd0)) else $error("clear cursor");

endmodule

bind ansi_terminal_escape_parser ate_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .write_cell_o, .cell_col_o, .cursor_col_o,
  .beep_o, .clear_screen_o
);
`default_nettype wire

### bench/ansi_terminal_escape_parser_tb.sv
`timescale 1ns / 1ps
module ansi_terminal_escape_parser_tb;
  import ate_pkg::*;

  localparam int MaxCols = 52;
  localparam int MaxRows = 30;
  localparam int NParams = 5;
  localparam int CycleLimit = 400000;

  // terminal state predictor and queue of expected words
  class term_scoreboard;
    int unsigned cols_reg, rows_reg, maxp_reg, dfg_reg, dbg_reg;
    parse_state_e pstate;
    int unsigned prm [NParams];
    int unsigned pidx;
    bit priv;
    int unsigned pcol, prow, scol, srow;
    bit shown;
    int unsigned fg, bg;
    res_t pending[$];
    int errors;

    function new();
      cols_reg = 40; rows_reg = 30; maxp_reg = 255; dfg_reg = 2016; dbg_reg = 0;
      pstate = PsReady;
      clr_prm();
      pcol = 0; prow = 0; scol = 0; srow = 0;
      shown = 1;
      fg = dfg_reg; bg = dbg_reg;
      errors = 0;
    endfunction

    function void clr_prm();
      foreach (prm[i]) prm[i] = 0;
      pidx = 0;
      priv = 0;
    endfunction

    function int unsigned ncols();
      return cols_reg == 0 ? 1 : (cols_reg > MaxCols ? MaxCols : cols_reg);
    endfunction

    function int unsigned nrows();
      return rows_reg == 0 ? 1 : (rows_reg > MaxRows ? MaxRows : rows_reg);
    endfunction

    function int unsigned pack565(int unsigned r, int unsigned g, int unsigned b);
      if (r > 255) r = 255;
      if (g > 255) g = 255;
      if (b > 255) b = 255;
      return ((r & 'hF8) << 8) | ((g & 'hFC) << 3) | (b >> 3);
    endfunction

    function int unsigned pal(int unsigned i);
      int unsigned lo, hi;
      i = i & 15;
      lo = (i & 8) ? 'h55 : 0;
      hi = (i & 8) ? 'hFF : 'hAA;
      if (i == 3) return pack565('hAA, 'h55, 0);
      if (i == 7) return pack565('hAA, 'hAA, 'hAA);
      if (i == 8) return pack565('h55, 'h55, 'h55);
      if (i == 12) return pack565(0, 0, 'hFF);
      return pack565((i & 1) ? hi : lo, (i & 2) ? hi : lo, (i & 4) ? hi : lo);
    endfunction

    function int unsigned cube(int unsigned n);
      int unsigned c, gr;
      if (n <= 15) return pal(n);
      if (n <= 231) begin
        c = n - 16;
        return pack565((c / 36) * 42, ((c % 36) / 6) * 42, (c % 6) * 42);
      end
      gr = (n - 232) * 10;
      return pack565(gr, gr, gr);
    endfunction

    function void clamp_all();
      if (pcol >= ncols()) pcol = ncols() - 1;
      if (prow >= nrows()) prow = nrows() - 1;
      if (scol >= ncols()) scol = ncols() - 1;
      if (srow >= nrows()) srow = nrows() - 1;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, int unsigned v);
      case (idx)
        RegColumns:  begin cols_reg = v & 'h3F; clamp_all(); end
        RegRows:     begin rows_reg = v & 'h1F; clamp_all(); end
        RegMaxPrint: maxp_reg = v & 'hFF;
        RegDefFg:    dfg_reg = v & 'hFFFF;
        RegDefBg:    dbg_reg = v & 'hFFFF;
        default: ;
      endcase
    endfunction

    function void do_clear(ref res_t r);
      pcol = 0; prow = 0; fg = dfg_reg; bg = dbg_reg;
      r.clear_screen = 1'b1;
    endfunction

    function int unsigned down_row();
      if (prow + 1 >= nrows()) begin
        prow = nrows() - 1;
        return 1;
      end
      prow++;
      return 0;
    endfunction

    function void apply_sgr();
      int unsigned p0, p1, p2, v;
      p0 = prm[0]; p1 = prm[1]; p2 = prm[2];
      if (p0 >= 30 && p0 <= 37) fg = pal(p0 - 30);
      if (p0 >= 40 && p0 <= 47) bg = pal(p0 - 40);
      if (p0 >= 90 && p0 <= 97) fg = pal(p0 - 82);
      if (p0 >= 100 && p0 <= 107) bg = pal(p0 - 92);
      if ((p0 == 38 || p0 == 48) && p1 == 5 && p2 <= 255) begin
        if (p0 == 38) fg = cube(p2); else bg = cube(p2);
      end
      if ((p0 == 38 || p0 == 48) && p1 == 2) begin
        v = pack565(p2, prm[3], prm[4]);
        if (p0 == 38) fg = v; else bg = v;
      end
    endfunction

    function void run_final(byte unsigned f, ref res_t r);
      int unsigned p0, n, c, rw, a, b;
      p0 = prm[0];
      n = p0 == 0 ? 1 : p0;
      c = ncols(); rw = nrows();
      case (f)
        "H": begin
          a = p0 == 0 ? 0 : p0 - 1;
          b = prm[1] == 0 ? 0 : prm[1] - 1;
          prow = a >= rw ? rw - 1 : a;
          pcol = b >= c ? c - 1 : b;
        end
        "h": if (priv && p0 == 25) shown = 1;
        "l": if (priv && p0 == 25) shown = 0;
        "m": apply_sgr();
        "s": begin scol = pcol; srow = prow; end
        "u": begin pcol = scol; prow = srow; end
        "J": if (p0 == 2 || p0 == 3) do_clear(r);
        "A": prow = prow >= n ? prow - n : 0;
        "B": prow = (prow + n >= rw) ? rw - 1 : prow + n;
        "C": pcol = (pcol + n >= c) ? c - 1 : pcol + n;
        "D": pcol = pcol >= n ? pcol - n : 0;
        "S": r.scroll_lines = 5'(n > rw ? rw : n);
        default: ;
      endcase
    endfunction

    function void note_byte(byte unsigned b);
      res_t r;
      int unsigned v, t;
      r = '0;
      if (pstate == PsEsc) begin
        if (b == "[") begin clr_prm(); pstate = PsCsi; end
        else pstate = PsReady;
      end else if (pstate == PsCsi) begin
        if (b >= "0" && b <= "9") begin
          if (pidx < NParams) begin
            v = prm[pidx] * 10 + (b - "0");
            prm[pidx] = v > 'hFFFF ? 'hFFFF : v;
          end
        end else if (b == ";") begin
          if (pidx < NParams) pidx++;
        end else if (b == "?") begin
          priv = 1;
        end else if (b >= 'h40 && b < 'h7E) begin
          run_final(b, r);
          clr_prm();
          pstate = PsReady;
        end
      end else begin
        if (b >= 'h20 && b <= maxp_reg) begin
          r.write_cell = 1'b1; r.cell_col = 6'(pcol); r.cell_row = 5'(prow);
          r.cell_char = b;
          r.cell_fg = 16'(fg); r.cell_bg = 16'(bg);
          if (pcol + 1 >= ncols()) begin
            pcol = 0;
            r.scroll_lines = 5'(down_row());
          end else pcol++;
        end else if (b == ChEsc) begin
          pstate = PsEsc;
        end else begin
          case (b)
            ChBs:  if (pcol > 0) pcol--;
            ChLf:  begin r.scroll_lines = 5'(down_row()); pcol = 0; end
            ChCr:  pcol = 0;
            ChFf:  do_clear(r);
            ChBel: r.beep = 1'b1;
            ChTab: begin
              t = (pcol + 8) & 'hFFF8;
              pcol = t >= ncols() ? ncols() - 1 : t;
            end
            default: ;
          endcase
        end
      end
      r.cursor_col = 6'(pcol); r.cursor_row = 5'(prow); r.cursor_shown = shown;
      pending.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_word(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      w = pending.pop_front();
      if (got.write_cell != w.write_cell) report("write_cell", got.write_cell, w.write_cell);
      if (got.cell_col != w.cell_col) report("cell_col", got.cell_col, w.cell_col);
      if (got.cell_row != w.cell_row) report("cell_row", got.cell_row, w.cell_row);
      if (got.cell_char != w.cell_char) report("cell_char", got.cell_char, w.cell_char);
      if (got.cell_fg != w.cell_fg) report("cell_fg", got.cell_fg, w.cell_fg);
      if (got.cell_bg != w.cell_bg) report("cell_bg", got.cell_bg, w.cell_bg);
      if (got.scroll_lines != w.scroll_lines)
        report("scroll_lines", got.scroll_lines, w.scroll_lines);
      if (got.clear_screen != w.clear_screen)
        report("clear_screen", got.clear_screen, w.clear_screen);
      if (got.beep != w.beep) report("beep", got.beep, w.beep);
      if (got.cursor_col != w.cursor_col) report("cursor_col", got.cursor_col, w.cursor_col);
      if (got.cursor_row != w.cursor_row) report("cursor_row", got.cursor_row, w.cursor_row);
      if (got.cursor_shown != w.cursor_shown)
        report("cursor_shown", got.cursor_shown, w.cursor_shown);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic push = 0;
  logic [7:0] rx_byte_i = '0;
  logic pop = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic full, empty;
  res_t dut_word;

  term_scoreboard sb;
  int unsigned cycles = 0;
  int hold_off = 0;
  int rx_wait = 0;
  int rx_draw;
  int sent = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  ansi_terminal_escape_parser u_top (
    .clk_i, .rst_ni, .push, .full, .rx_byte_i, .empty, .pop,
    .write_cell_o(dut_word.write_cell), .cell_col_o(dut_word.cell_col),
    .cell_row_o(dut_word.cell_row), .cell_char_o(dut_word.cell_char),
    .cell_fg_o(dut_word.cell_fg), .cell_bg_o(dut_word.cell_bg),
    .scroll_lines_o(dut_word.scroll_lines), .clear_screen_o(dut_word.clear_screen),
    .beep_o(dut_word.beep), .cursor_col_o(dut_word.cursor_col),
    .cursor_row_o(dut_word.cursor_row), .cursor_shown_o(dut_word.cursor_shown),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout");
      $display("FAIL ansi_terminal_escape_parser");
      $finish;
    end
  end

  // receiver: drawn wait per word, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_word(dut_word);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 0;
      end else if (pop && !empty) begin
        rx_draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
        rx_wait <= rx_draw;
        pop <= (rx_draw == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        pop <= (rx_wait == 1);
      end else begin
        pop <= 1;
      end
    end
  end

  task automatic send_byte(input int unsigned v);
    byte unsigned b;
    int gap;
    b = 8'(v);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    sb.note_byte(b);
    sent++;
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic drain();
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(v);
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_num(input int unsigned v);
    send_str($sformatf("%0d", v));
  endtask

  // printable and random bytes, control pairs, and mostly well-formed escape sequences with random content
  task automatic random_seq();
    int k;
    string fins;
    fins = "HABCDsuJSmhlKX@}";
    k = $urandom_range(0, 9);
    if (k < 4) begin
      send_byte($urandom_range(32, 126));
    end else if (k == 4) begin
      send_byte($urandom_range(0, 255));
    end else if (k == 5) begin
      send_byte($urandom_range(0, 1) ? ChLf : ChCr);
      send_byte($urandom_range(0, 1) ? ChTab : ChBs);
    end else begin
      send_byte(ChEsc);
      if ($urandom_range(0, 9) == 0) begin
        send_byte($urandom_range(0, 255));
        return;
      end
      send_byte("[");
      if ($urandom_range(0, 3) == 0) send_byte("?");
      case ($urandom_range(0, 4))
        0: begin send_num(25); send_byte($urandom_range(0, 1) ? "h" : "l"); end
        1: begin
          send_num($urandom_range(0, 1) ? 38 : 48); send_byte(";");
          send_num(5); send_byte(";"); send_num($urandom_range(0, 300)); send_byte("m");
        end
        2: begin
          send_num($urandom_range(0, 1) ? 38 : 48); send_str(";2;");
          send_num($urandom_range(0, 300)); send_byte(";");
          send_num($urandom_range(0, 300)); send_byte(";");
          send_num($urandom_range(0, 300)); send_byte("m");
        end
        3: begin
          repeat ($urandom_range(0, 7)) begin
            if ($urandom_range(0, 2) == 0) send_byte(";");
            else send_byte($urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(48, 57));
          end
          send_byte(fins[$urandom_range(0, fins.len() - 1)]);
        end
        default: begin
          send_num($urandom_range(0, 110)); send_byte(";");
          send_num($urandom_range(0, 60)); send_byte(fins[$urandom_range(0, 9)]);
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed
    send_str("A~");
    send_byte(8'hFF); send_byte(8'h00); send_byte(ChBel); send_byte(ChTab);
    send_byte(ChBs); send_byte(ChLf); send_byte(ChCr);
    send_str("\033[31m\033[?25l\033[99999;9;9;9;9;9mZ");
    send_byte(ChFf);
    drain();

    write_reg(RegColumns, 1);
    write_reg(RegRows, 1);
    write_reg(RegMaxPrint, 32);
    write_reg(RegDefFg, 16'hFFFF);
    write_reg(RegDefBg, 16'hFFFF);
    send_str(" ab\033[5S\033[2J");
    drain();

    // fill the block while the receiver stalls
    hold_off <= 60;
    send_str("xxxxxxxxxxxx");
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(RegColumns, 52); write_reg(RegRows, 30); end
        1: begin write_reg(RegColumns, 63); write_reg(RegRows, 31); end
        2: begin write_reg(RegColumns, 0); write_reg(RegRows, 0); end
        default: begin
          write_reg(RegColumns, $urandom_range(1, 52));
          write_reg(RegRows, $urandom_range(1, 30));
        end
      endcase
      write_reg(RegMaxPrint, phase == 1 ? 255 : $urandom_range(32, 255));
      write_reg(RegDefFg, $urandom_range(0, 65535));
      write_reg(RegDefBg, phase == 0 ? 0 : $urandom_range(0, 65535));
      while (sent < 300 + phase * 250) random_seq();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS ansi_terminal_escape_parser");
    end else begin
      $display("FAIL ansi_terminal_escape_parser");
    end
    $finish;
  end
endmodule
